@@ rtl/dtq_pkg.sv @@
// Shared types, constants and helpers of the deadline timer queue.
package dtq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int RC_W = 5;
  localparam int TIME_W = 48;
  localparam int AMT_W = 32;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SCHEDULE = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  localparam logic [1:0] KIND_SCHED_ACK = 2'd0;
  localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_NONE_DUE = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [AMT_W-1:0]  time_amount;
    logic [7:0]        pointer_id;
    logic [7:0]        owner_id;
  } item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic              status;
    logic [7:0]        fired_pointer;
    logic [7:0]        fired_owner;
    logic [TIME_W-1:0] fired_deadline;
    logic [RC_W-1:0]   removed_count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] deadline;
    logic [7:0]        pointer;
    logic [7:0]        owner;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_POP     = 3'd2,
    CELL_MARK    = 3'd3,
    CELL_COMPACT = 3'd4
  } cell_op_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t          op;
    entry_t            fresh;
    logic [TIME_W-1:0] now;
    logic [7:0]        owner;
  } cell_cmd_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [AMT_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - AMT_W){1'b0}}, b};
    sat_add = s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

@@ rtl/dtq_cell.sv @@
// One slot of the timer row: holds an entry and trades it with its neighbors.
module dtq_cell (
  input  logic                clk,
  input  logic                rst,
  input  dtq_pkg::cell_cmd_t  ctl,
  input  dtq_pkg::entry_t     left,
  input  logic                left_ins,
  input  logic                left_hole,
  input  dtq_pkg::entry_t     right,
  output dtq_pkg::entry_t     ent,
  output logic                ins,
  output logic                hole,
  output logic                due
);

  logic                         valid;
  logic [dtq_pkg::TIME_W-1:0]   deadline;
  logic [7:0]                   pointer;
  logic [7:0]                   owner;
  dtq_pkg::entry_t              ent_next;

  assign ent = '{valid: valid, deadline: deadline, pointer: pointer, owner: owner};

  // The row stays sorted by deadline, so the insert point is the first slot that
  // is empty or holds a strictly later deadline; equal deadlines stay ahead.
  assign ins  = !valid || (deadline > ctl.fresh.deadline);
  assign hole = !valid || left_hole;
  assign due  = valid && (deadline <= ctl.now);

  always_comb begin
    ent_next = ent;
    unique case (ctl.op)
      dtq_pkg::CELL_HOLD: begin
      end
      dtq_pkg::CELL_INSERT: begin
        if (left_ins) begin
          ent_next = left;
        end else if (ins) begin
          ent_next = ctl.fresh;
        end
      end
      dtq_pkg::CELL_POP: begin
        ent_next = right;
      end
      dtq_pkg::CELL_MARK: begin
        if (valid && (owner == ctl.owner)) begin
          ent_next.valid = 1'b0;
        end
      end
      dtq_pkg::CELL_COMPACT: begin
        // Everything behind the first hole slides one slot toward the head.
        if (hole) begin
          ent_next = right;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ent_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    deadline <= ent_next.deadline;
    pointer  <= ent_next.pointer;
    owner    <= ent_next.owner;
  end

endmodule

@@ rtl/deadline_timer_queue_core.sv @@
// Top level of the deadline timer queue: control, clock and the row of cells.
//
//   channel  dir  handshake              beat
//   cmd      in   cmd_valid / cmd_stall  item_t: opcode, time_amount, pointer_id, owner_id
//   rsp      out  rsp_valid / rsp_stall  result_t: one result per beat, last marks the end
//
// Schedule inserts; cancel marks the owner's entries, then compacts the row; tick pops
// each fired entry. The row shifts one slot per cycle; results wait while rsp is stalled.
// The row is kept sorted by deadline, so due entries always leave from the head cell.
// Reset is synchronous and empties the row and zeroes the clock.
// cmd is taken whenever the control is idle, even while a result still waits on rsp.
module deadline_timer_queue_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  dtq_pkg::item_t   cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output dtq_pkg::result_t rsp
);

  localparam int N = dtq_pkg::TABLE_DEPTH;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCHED   = 5'b00010,
    ST_MARK    = 5'b00100,
    ST_COMPACT = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  state_t                         state, state_next;
  logic [dtq_pkg::TIME_W-1:0]     clock_now;
  logic [dtq_pkg::TIME_W-1:0]     new_deadline;
  logic [7:0]                     pointer_reg;
  logic [7:0]                     owner_reg;
  logic [dtq_pkg::CNT_W-1:0]      fill_before;
  logic [dtq_pkg::CNT_W-1:0]      fill;
  logic [dtq_pkg::IDX_W-1:0]      sweep;
  logic                           cancel_ack;
  logic                           out_free;
  logic                           accept;
  dtq_pkg::result_t               rsp_next;

  dtq_pkg::cell_cmd_t             ctl;
  dtq_pkg::entry_t                ents [N];
  logic [N-1:0]                   ins;
  logic [N-1:0]                   hole;
  logic [N-1:0]                   due;
  logic [N-1:0]                   vld;
  logic [N:0]                     vld_ext;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Row of cells.
  for (genvar g = 0; g < N; g++) begin : g_row
    dtq_pkg::entry_t left_e;
    dtq_pkg::entry_t right_e;
    logic            left_i;
    logic            left_h;
    if (g == 0) begin : g_head
      assign left_e = '0;
      assign left_i = 1'b0;
      assign left_h = 1'b0;
    end else begin : g_mid
      assign left_e = ents[g-1];
      assign left_i = ins[g-1];
      assign left_h = hole[g-1];
    end
    if (g == N - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = ents[g+1];
    end
    dtq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (left_e),
      .left_ins  (left_i),
      .left_hole (left_h),
      .right     (right_e),
      .ent       (ents[g]),
      .ins       (ins[g]),
      .hole      (hole[g]),
      .due       (due[g])
    );
    assign vld[g] = ents[g].valid;
  end

  // Valid entries form a prefix, so the fill level is where that prefix ends.
  assign vld_ext = {1'b0, vld};
  always_comb begin
    fill = '0;
    for (int i = 0; i < N; i++) begin
      if (vld_ext[i] && !vld_ext[i+1]) begin
        fill = dtq_pkg::CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    ctl.op    = dtq_pkg::CELL_HOLD;
    ctl.fresh = '{valid: 1'b1, deadline: new_deadline, pointer: pointer_reg, owner: owner_reg};
    ctl.now   = clock_now;
    ctl.owner = owner_reg;
    state_next = state;
    cancel_ack = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (cmd.opcode)
            dtq_pkg::OP_TICK:     state_next = ST_EMIT;
            dtq_pkg::OP_SCHEDULE: state_next = ST_SCHED;
            dtq_pkg::OP_CANCEL:   state_next = ST_MARK;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCHED: begin
        if (out_free) begin
          if (!vld[N-1]) begin
            ctl.op = dtq_pkg::CELL_INSERT;
          end
          state_next = ST_IDLE;
        end
      end
      ST_MARK: begin
        ctl.op     = dtq_pkg::CELL_MARK;
        state_next = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (sweep != dtq_pkg::IDX_W'(N - 1)) begin
          ctl.op = dtq_pkg::CELL_COMPACT;
        end else if (out_free) begin
          cancel_ack = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (due[0]) begin
            ctl.op = dtq_pkg::CELL_POP;
            if (!due[1]) begin
              state_next = ST_IDLE;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clock_now <= '0;
      sweep     <= '0;
    end else begin
      state <= state_next;
      if (accept && (cmd.opcode == dtq_pkg::OP_TICK)) begin
        clock_now <= dtq_pkg::sat_add(clock_now, cmd.time_amount);
      end
      if (state == ST_COMPACT) begin
        if (ctl.op == dtq_pkg::CELL_COMPACT) begin
          sweep <= sweep + 1'b1;
        end
      end else begin
        sweep <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      new_deadline <= dtq_pkg::sat_add(clock_now, cmd.time_amount);
      pointer_reg  <= cmd.pointer_id;
      owner_reg    <= cmd.owner_id;
      fill_before  <= fill;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= (state == ST_SCHED) || (state == ST_EMIT) || cancel_ack;
    end
  end

  always_comb begin
    rsp_next = '0;
    if (state == ST_SCHED) begin
      rsp_next.result_kind = dtq_pkg::KIND_SCHED_ACK;
      rsp_next.status      = vld[N-1];
      rsp_next.last        = 1'b1;
    end else if (cancel_ack) begin
      rsp_next.result_kind   = dtq_pkg::KIND_CANCEL_ACK;
      rsp_next.removed_count = dtq_pkg::RC_W'(fill_before - fill);
      rsp_next.last          = 1'b1;
    end else if (state == ST_EMIT) begin
      if (due[0]) begin
        rsp_next.result_kind    = dtq_pkg::KIND_FIRED;
        rsp_next.fired_pointer  = ents[0].pointer;
        rsp_next.fired_owner    = ents[0].owner;
        rsp_next.fired_deadline = ents[0].deadline;
        rsp_next.last           = !due[1];
      end else begin
        rsp_next.result_kind = dtq_pkg::KIND_NONE_DUE;
        rsp_next.last        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      rsp <= rsp_next;
    end
  end

endmodule
